@@ rtl/core/mss_pkg.sv @@
package mss_pkg;

  typedef enum logic [1:0] {
    PH_LOAD,
    PH_STRIP,
    PH_KADANE,
    PH_EMIT
  } phase_e;

  localparam int unsigned CfgIdxW = 7;
  localparam logic [CfgIdxW-1:0] RegRowCount    = 7'd0;
  localparam logic [CfgIdxW-1:0] RegColumnCount = 7'd1;
  localparam int unsigned CfgDataW = 7;
  localparam int unsigned OutSumW  = 27;
  localparam int unsigned IdxOutW  = 6;

  typedef struct packed {
    logic clear;
    logic add;
    logic shift;
  } cell_ctrl_t;

endpackage

@@ rtl/core/mss_cell.sv @@
module mss_cell #(
  parameter int unsigned SumW = 28
) (
  input  logic               clk_i,
  input  mss_pkg::cell_ctrl_t ctrl_i,
  input  logic signed [SumW-1:0] add_i,
  input  logic signed [SumW-1:0] shift_i,
  output logic signed [SumW-1:0] sum_o
);

  logic signed [SumW-1:0] sum_q, sum_d;

  always_comb begin
    sum_d = sum_q;
    if (ctrl_i.clear) begin
      sum_d = '0;
    end else if (ctrl_i.add) begin
      sum_d = sum_q + add_i;
    end else if (ctrl_i.shift) begin
      sum_d = shift_i;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
  end

  assign sum_o = sum_q;

endmodule

@@ rtl/core/max_sum_submatrix_core.sv @@
// Channel | Ports                                          | Beat
// config  | cfg_we_i cfg_index_i cfg_data_i                | cfg_we_i high
// element | start_i busy_o element_value_i                 | start_i & !busy_o
// result  | done_o best_sum_o top_row_o ... right_column_o | done_o, one cycle
// Elements load one per cycle into the store. After the last one the search
// walks every column pair: first it adds the column into the row of strip
// cells (one store read a cycle, through the registered read port), then it
// rotates the chain through the Kadane unit and folds in the pass best.
// There are cols*(cols+1)/2 pairs; then the emit state registers the done_o
// beat. Reset clears control state; the store needs no clearing. Results
// cannot stall.
module max_sum_submatrix_core #(
  parameter int unsigned MAX_ROWS    = 64,
  parameter int unsigned MAX_COLUMNS = 64,
  parameter int unsigned DATA_WIDTH  = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [mss_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [mss_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic start_i,
  output logic busy_o,
  input  logic signed [DATA_WIDTH-1:0] element_value_i,
  output logic done_o,
  output logic [mss_pkg::OutSumW-1:0] best_sum_o,
  output logic [mss_pkg::IdxOutW-1:0] top_row_o,
  output logic [mss_pkg::IdxOutW-1:0] bottom_row_o,
  output logic [mss_pkg::IdxOutW-1:0] left_column_o,
  output logic [mss_pkg::IdxOutW-1:0] right_column_o
);

  localparam int unsigned Depth = MAX_ROWS * MAX_COLUMNS;
  localparam int unsigned RW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned SumW = DATA_WIDTH + RW + 2 * CW + 2;
  localparam int unsigned CntW = mss_pkg::CfgDataW;

  logic [CntW-1:0] row_cfg_q, col_cfg_q;
  logic [RW:0] rows;
  logic [CW:0] cols;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cfg_q <= CntW'(1);
      col_cfg_q <= CntW'(1);
    end else if (cfg_we_i) begin
      if (cfg_index_i == mss_pkg::RegRowCount) row_cfg_q <= cfg_data_i;
      if (cfg_index_i == mss_pkg::RegColumnCount) col_cfg_q <= cfg_data_i;
    end
  end

  always_comb begin
    if (row_cfg_q == '0) rows = (RW+1)'(1);
    else if (32'(row_cfg_q) > MAX_ROWS) rows = (RW+1)'(MAX_ROWS);
    else rows = (RW+1)'(row_cfg_q);
    if (col_cfg_q == '0) cols = (CW+1)'(1);
    else if (32'(col_cfg_q) > MAX_COLUMNS) cols = (CW+1)'(MAX_COLUMNS);
    else cols = (CW+1)'(col_cfg_q);
  end

  mss_pkg::phase_e phase_q, phase_d;
  logic [AW:0] load_q, load_d;
  logic [CW:0] left_q, left_d, right_q, right_d;
  logic [RW:0] r_q, r_d;
  logic [AW:0] base_q, base_d;
  logic rd_v_q, rd_v_d;
  logic signed [SumW-1:0] run_q, run_d, pbest_q, pbest_d, obest_q, obest_d;
  logic [RW-1:0] rstart_q, rstart_d, ptop_q, ptop_d, pbot_q, pbot_d;
  logic [4*mss_pkg::IdxOutW-1:0] corn_q, corn_d;
  logic done_q, done_d;

  logic signed [DATA_WIDTH-1:0] mem [Depth];
  logic signed [DATA_WIDTH-1:0] rd_q;
  logic [AW-1:0] rd_addr;
  logic mem_we;
  logic [AW-1:0] wr_addr;
  logic [AW:0] total;

  assign total = (AW+1)'(rows * cols);

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[wr_addr] <= element_value_i;
    rd_q <= mem[rd_addr];
  end

  mss_pkg::cell_ctrl_t ctrl;
  logic signed [SumW-1:0] cell_sum [MAX_ROWS];
  logic signed [SumW-1:0] add_v;
  logic signed [SumW-1:0] head;
  logic signed [SumW-1:0] strip_v;

  assign add_v = SumW'(rd_q);
  assign head = cell_sum[0];

  for (genvar g = 0; g < MAX_ROWS; g++) begin : g_cell
    mss_pkg::cell_ctrl_t cc;
    logic signed [SumW-1:0] shin;
    always_comb begin
      cc = ctrl;
      cc.add = ctrl.add && (r_q[RW-1:0] == RW'(g)) && rd_v_q;
      if (32'(g) + 1 < 32'(rows)) shin = (g + 1 < MAX_ROWS) ? cell_sum[(g+1)%MAX_ROWS] : head;
      else shin = head;
    end
    mss_cell #(.SumW(SumW)) u_cell (
      .clk_i(clk_i), .ctrl_i(cc), .add_i(add_v), .shift_i(shin), .sum_o(cell_sum[g])
    );
  end

  // add phase: read index base+row*cols; rd data is registered in rd_q
  logic [RW:0] ar_q, ar_d;
  logic signed [SumW-1:0] run_new;
  logic [RW-1:0] start_new;

  assign strip_v = head;

  always_comb begin
    phase_d = phase_q;
    load_d = load_q;
    left_d = left_q;
    right_d = right_q;
    r_d = r_q;
    ar_d = ar_q;
    base_d = base_q;
    rd_v_d = 1'b0;
    run_d = run_q;
    pbest_d = pbest_q;
    obest_d = obest_q;
    rstart_d = rstart_q;
    ptop_d = ptop_q;
    pbot_d = pbot_q;
    corn_d = corn_q;
    done_d = 1'b0;
    mem_we = 1'b0;
    wr_addr = load_q[AW-1:0];
    rd_addr = base_q[AW-1:0];
    ctrl = '0;
    run_new = '0;
    start_new = rstart_q;
    case (phase_q)
      mss_pkg::PH_LOAD: begin
        if (start_i) begin
          mem_we = 1'b1;
          if (load_q + 1'b1 >= total) begin
            load_d = '0;
            phase_d = mss_pkg::PH_STRIP;
            left_d = '0;
            right_d = '0;
            ar_d = '0;
            r_d = '0;
            base_d = '0;
            obest_d = '0;
            corn_d = '0;
            ctrl.clear = 1'b1;
          end else begin
            load_d = load_q + 1'b1;
          end
        end
      end
      mss_pkg::PH_STRIP: begin
        ctrl.add = 1'b1;
        if (ar_q < rows) begin
          rd_v_d = 1'b1;
          base_d = base_q + (AW+1)'(cols);
          ar_d = ar_q + 1'b1;
        end
        if (rd_v_q) r_d = r_q + 1'b1;
        if (ar_q == rows && !rd_v_q) begin
          phase_d = mss_pkg::PH_KADANE;
          r_d = '0;
          run_d = '0;
          rstart_d = '0;
          pbest_d = '0;
          ptop_d = '0;
          pbot_d = '0;
        end
      end
      mss_pkg::PH_KADANE: begin
        if (r_q < rows) begin
          ctrl.shift = 1'b1;
          if (run_q <= 0) begin
            run_new = strip_v;
            start_new = r_q[RW-1:0];
          end else begin
            run_new = run_q + strip_v;
          end
          run_d = run_new;
          rstart_d = start_new;
          if (run_new > pbest_q) begin
            pbest_d = run_new;
            ptop_d = start_new;
            pbot_d = r_q[RW-1:0];
          end
          r_d = r_q + 1'b1;
        end else begin
          if (pbest_q > obest_q) begin
            obest_d = pbest_q;
            corn_d = {6'(ptop_q), 6'(pbot_q), 6'(left_q), 6'(right_q)};
          end
          r_d = '0;
          ar_d = '0;
          phase_d = mss_pkg::PH_STRIP;
          if (right_q + 1'b1 < cols) begin
            right_d = right_q + 1'b1;
            base_d = (AW+1)'(right_q + 1'b1);
          end else if (left_q + 1'b1 < cols) begin
            left_d = left_q + 1'b1;
            right_d = left_q + 1'b1;
            base_d = (AW+1)'(left_q + 1'b1);
            ctrl.clear = 1'b1;
          end else begin
            phase_d = mss_pkg::PH_EMIT;
          end
        end
      end
      mss_pkg::PH_EMIT: begin
        done_d = 1'b1;
        phase_d = mss_pkg::PH_LOAD;
      end
      default: phase_d = mss_pkg::PH_LOAD;
    endcase
    if (cfg_we_i && (cfg_index_i == mss_pkg::RegRowCount ||
                     cfg_index_i == mss_pkg::RegColumnCount)) begin
      load_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= mss_pkg::PH_LOAD;
      load_q <= '0;
      done_q <= 1'b0;
      rd_v_q <= 1'b0;
      left_q <= '0;
      right_q <= '0;
      r_q <= '0;
      ar_q <= '0;
      base_q <= '0;
    end else begin
      phase_q <= phase_d;
      load_q <= load_d;
      done_q <= done_d;
      rd_v_q <= rd_v_d;
      left_q <= left_d;
      right_q <= right_d;
      r_q <= r_d;
      ar_q <= ar_d;
      base_q <= base_d;
    end
  end

  always_ff @(posedge clk_i) begin
    run_q <= run_d;
    pbest_q <= pbest_d;
    obest_q <= obest_d;
    rstart_q <= rstart_d;
    ptop_q <= ptop_d;
    pbot_q <= pbot_d;
    corn_q <= corn_d;
  end

  assign busy_o = (phase_q != mss_pkg::PH_LOAD);
  assign done_o = done_q;
  assign best_sum_o = mss_pkg::OutSumW'(obest_q);
  assign top_row_o = corn_q[23:18];
  assign bottom_row_o = corn_q[17:12];
  assign left_column_o = corn_q[11:6];
  assign right_column_o = corn_q[5:0];

endmodule

@@ rtl/core/mss_checker.sv @@
module mss_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic start_i,
  input logic busy_o,
  input logic done_o
);

  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(busy_o)) else $error("done without busy");
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("done longer than one cycle");
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("busy during done");
  a_busy_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i)) else $error("busy without start");

endmodule

bind max_sum_submatrix_core mss_checker u_mss_checker (
  .clk_i(clk_i), .rst_ni(rst_ni), .start_i(start_i), .busy_o(busy_o), .done_o(done_o)
);
